[rtl/table_interpolator_lin_log_assert.svh]
// ----------------------------------------------------------------------------
// Table interpolator assertion macros
// Shared property forms for the interpolator checks, clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TABLE_INTERPOLATOR_LIN_LOG_ASSERT_SVH
`define TABLE_INTERPOLATOR_LIN_LOG_ASSERT_SVH

`define TIL_ASSERT_SAME(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

`define TIL_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`define TIL_ASSERT_LATER(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##2 (expr)) \
    else $error(msg);

`endif

[rtl/til_pkg.sv]
// ----------------------------------------------------------------------------
// Table interpolator package
// Beat types, codes, controller/datapath interface and exp2 root constants.
// ----------------------------------------------------------------------------
package til_pkg;

  localparam int LOG_FRAC = 24;

  typedef struct packed {
    logic               op;
    logic [7:0]         entry_index;
    logic [31:0]        point_x;
    logic signed [31:0] point_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] result_y;
    logic [2:0]         status;
  } out_beat_t;

  typedef enum logic [0:0] {
    REG_INTERP_MODE = 1'b0,
    REG_POINT_COUNT = 1'b1
  } cfg_reg_t;

  localparam logic [1:0] MODE_LIN_LIN  = 2'd0;
  localparam logic [1:0] MODE_LOG_LOG  = 2'd1;
  localparam logic [1:0] MODE_LIN_LOGY = 2'd2;
  localparam logic [1:0] MODE_LOGX_LIN = 2'd3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_CLAMP_LOW  = 3'd1;
  localparam logic [2:0] ST_CLAMP_HIGH = 3'd2;
  localparam logic [2:0] ST_NONPOS_Y   = 3'd3;
  localparam logic [2:0] ST_ZERO_X     = 3'd4;
  localparam logic [2:0] ST_FLAT_SAT   = 3'd5;

  typedef enum logic [4:0] {
    DP_NONE, DP_CAPTURE, DP_WRITE, DP_RD_FIRST, DP_RD_LAST, DP_SEARCH_INIT,
    DP_RD_MID, DP_SEARCH_STEP, DP_RD_LO, DP_TAKE_LO, DP_TAKE_HI, DP_RES_FIRST,
    DP_RES_LAST, DP_RES_ZERO_Y, DP_RES_ZERO_X, DP_RES_FLAT, DP_LOG_START,
    DP_LOG_STEP, DP_LOG_STORE, DP_SPAN, DP_MUL_INIT, DP_MUL_STEP, DP_DIV_INIT,
    DP_DIV_STEP, DP_BLEND, DP_EXP_INIT, DP_EXP_STEP, DP_EXP_END, DP_SEND
  } dp_op_t;

  typedef enum logic [2:0] {
    SRC_XQ, SRC_X1, SRC_X2, SRC_Y1, SRC_Y2
  } log_src_t;

  typedef struct packed {
    dp_op_t     op;
    log_src_t   src;
    logic [4:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic below;
    logic above;
    logic more;
    logic y_nonpos;
    logic x1_zero;
    logic log_x;
    logic log_y;
    logic den_zero;
    logic out_full;
  } dp_status_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] res;
    logic [63:0] bv;
    a   = a_in;
    res = '0;
    bv  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (a >= res + bv) begin
        a   = a - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  function automatic logic [LOG_FRAC-1:0][31:0] exp_roots();
    logic [LOG_FRAC-1:0][31:0] tab;
    logic [63:0] c;
    c = 64'h1_0000_0000;
    for (int k = 0; k < LOG_FRAC; k++) begin
      c      = isqrt64(c << 31);
      tab[k] = c[31:0];
    end
    return tab;
  endfunction

  localparam logic [LOG_FRAC-1:0][31:0] EXP_ROOT = exp_roots();

endpackage

[rtl/til_ctrl.sv]
// ----------------------------------------------------------------------------
// Table interpolator controller
// Sequences loads and queries: search, logarithms, multiply, divide, exp2.
// ----------------------------------------------------------------------------
module til_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  input  til_pkg::dp_status_t status,
  output til_pkg::dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_WRITE, S_RD_FIRST, S_CHK_FIRST, S_CHK_LAST, S_SEARCH, S_STEP,
    S_TAKE_LO, S_TAKE_HI, S_CHECK, S_LOG_START, S_LOG, S_LOG_END, S_SPAN,
    S_SPAN_CHK, S_MUL, S_DIV_INIT, S_DIV, S_BLEND, S_EXP_INIT, S_EXP,
    S_EXP_END, S_SEND
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [5:0]        cnt;
  logic [5:0]        cnt_next;
  til_pkg::log_src_t src;
  til_pkg::log_src_t src_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 6'd1;
    src_next   = src;
    cmd.op     = til_pkg::DP_NONE;
    cmd.src    = src;
    cmd.step   = cnt[4:0];
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.op     = til_pkg::DP_CAPTURE;
          state_next = (in_op == til_pkg::OP_LOAD) ? S_WRITE : S_RD_FIRST;
        end
      end
      S_WRITE: begin
        cmd.op     = til_pkg::DP_WRITE;
        state_next = S_IDLE;
      end
      S_RD_FIRST: begin
        cmd.op     = til_pkg::DP_RD_FIRST;
        state_next = S_CHK_FIRST;
      end
      S_CHK_FIRST: begin
        if (status.below) begin
          cmd.op     = til_pkg::DP_RES_FIRST;
          state_next = S_SEND;
        end else begin
          cmd.op     = til_pkg::DP_RD_LAST;
          state_next = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        if (status.above) begin
          cmd.op     = til_pkg::DP_RES_LAST;
          state_next = S_SEND;
        end else begin
          cmd.op     = til_pkg::DP_SEARCH_INIT;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (status.more) begin
          cmd.op     = til_pkg::DP_RD_MID;
          state_next = S_STEP;
        end else begin
          cmd.op     = til_pkg::DP_RD_LO;
          state_next = S_TAKE_LO;
        end
      end
      S_STEP: begin
        cmd.op     = til_pkg::DP_SEARCH_STEP;
        state_next = S_SEARCH;
      end
      S_TAKE_LO: begin
        cmd.op     = til_pkg::DP_TAKE_LO;
        state_next = S_TAKE_HI;
      end
      S_TAKE_HI: begin
        cmd.op     = til_pkg::DP_TAKE_HI;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.y_nonpos) begin
          cmd.op     = til_pkg::DP_RES_ZERO_Y;
          state_next = S_SEND;
        end else if (status.x1_zero) begin
          cmd.op     = til_pkg::DP_RES_ZERO_X;
          state_next = S_SEND;
        end else if (status.log_x) begin
          src_next   = til_pkg::SRC_XQ;
          state_next = S_LOG_START;
        end else if (status.log_y) begin
          src_next   = til_pkg::SRC_Y1;
          state_next = S_LOG_START;
        end else begin
          state_next = S_SPAN;
        end
      end
      S_LOG_START: begin
        cmd.op     = til_pkg::DP_LOG_START;
        cnt_next   = '0;
        state_next = S_LOG;
      end
      S_LOG: begin
        cmd.op = til_pkg::DP_LOG_STEP;
        if (cnt == 6'(til_pkg::LOG_FRAC - 1)) begin
          state_next = S_LOG_END;
        end
      end
      S_LOG_END: begin
        cmd.op     = til_pkg::DP_LOG_STORE;
        state_next = S_LOG_START;
        case (src)
          til_pkg::SRC_XQ: src_next = til_pkg::SRC_X1;
          til_pkg::SRC_X1: src_next = til_pkg::SRC_X2;
          til_pkg::SRC_X2: begin
            if (status.log_y) begin
              src_next = til_pkg::SRC_Y1;
            end else begin
              state_next = S_SPAN;
            end
          end
          til_pkg::SRC_Y1: src_next = til_pkg::SRC_Y2;
          default: state_next = S_SPAN;
        endcase
      end
      S_SPAN: begin
        cmd.op     = til_pkg::DP_SPAN;
        state_next = S_SPAN_CHK;
      end
      S_SPAN_CHK: begin
        cnt_next = '0;
        if (status.den_zero) begin
          cmd.op     = til_pkg::DP_RES_FLAT;
          state_next = S_SEND;
        end else begin
          cmd.op     = til_pkg::DP_MUL_INIT;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op = til_pkg::DP_MUL_STEP;
        if (cnt == 6'd32) begin
          state_next = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd.op     = til_pkg::DP_DIV_INIT;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = til_pkg::DP_DIV_STEP;
        if (cnt == 6'd63) begin
          state_next = S_BLEND;
        end
      end
      S_BLEND: begin
        cmd.op     = til_pkg::DP_BLEND;
        state_next = status.log_y ? S_EXP_INIT : S_SEND;
      end
      S_EXP_INIT: begin
        cmd.op     = til_pkg::DP_EXP_INIT;
        cnt_next   = '0;
        state_next = S_EXP;
      end
      S_EXP: begin
        cmd.op = til_pkg::DP_EXP_STEP;
        if (cnt == 6'(til_pkg::LOG_FRAC - 1)) begin
          state_next = S_EXP_END;
        end
      end
      S_EXP_END: begin
        cmd.op     = til_pkg::DP_EXP_END;
        state_next = S_SEND;
      end
      S_SEND: begin
        if (!status.out_full) begin
          cmd.op     = til_pkg::DP_SEND;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      src   <= til_pkg::SRC_XQ;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      src   <= src_next;
    end
  end

endmodule

[rtl/til_datapath.sv]
// ----------------------------------------------------------------------------
// Table interpolator datapath
// Point table, configuration registers, search pointers, serial log2,
// multiply, divide and exp2 units, and the output register.
// ----------------------------------------------------------------------------
module til_datapath #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  til_pkg::dp_cmd_t    cmd,
  output til_pkg::dp_status_t status,
  input  til_pkg::in_beat_t   in_data,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [8:0]          cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output til_pkg::out_beat_t  out_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LF = til_pkg::LOG_FRAC;

  logic [31:0] table_x [TABLE_DEPTH];
  logic [31:0] table_y [TABLE_DEPTH];

  logic [1:0]  interp_mode;
  logic [8:0]  point_count;

  logic [7:0]  q_index;
  logic [31:0] xq;
  logic [31:0] q_y;
  logic [31:0] rd_x;
  logic [31:0] rd_y;
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  logic [31:0] x1;
  logic [31:0] x2;
  logic [31:0] y1;
  logic [31:0] y2;
  logic signed [31:0] lq;
  logic signed [31:0] l1;
  logic signed [31:0] l2;
  logic signed [31:0] ly1;
  logic signed [31:0] ly2;
  logic [4:0]  lg_e;
  logic [31:0] lg_m;
  logic [LF-1:0] lg_frac;
  logic [31:0] num;
  logic [31:0] den;
  logic signed [31:0] base;
  logic [32:0] mag;
  logic        neg;
  logic [63:0] acc;
  logic [63:0] mcand;
  logic [32:0] mplier;
  logic [63:0] dvd;
  logic [32:0] rem;
  logic signed [33:0] bl;
  logic [32:0] ep;
  logic [LF-1:0] ef;
  logic signed [9:0] eip;
  logic [31:0] res_y;
  logic [2:0]  res_st;

  logic [31:0] pc32;
  logic [31:0] last32;
  logic [AW-1:0] n_last;
  logic [AW:0] mid_sum;
  logic [AW-1:0] mid;
  logic [AW-1:0] rd_addr;
  logic        rd_en;
  logic [31:0] idx32;
  logic        log_x;
  logic        log_y;
  logic [31:0] lg_src;
  logic [4:0]  lead;
  logic [63:0] lg_sq;
  logic signed [31:0] lg_val;
  logic [32:0] div_sh;
  logic [32:0] quot;
  logic [64:0] ep_prod;
  logic [64:0] ep_sum;
  logic signed [10:0] es;
  logic [10:0] sh;
  logic [33:0] rnd;
  logic [33:0] rr;
  logic [31:0] exp_r;
  logic        exp_sat;
  logic signed [32:0] dd;

  assign log_x = (interp_mode == til_pkg::MODE_LOG_LOG) ||
                 (interp_mode == til_pkg::MODE_LOGX_LIN);
  assign log_y = (interp_mode == til_pkg::MODE_LOG_LOG) ||
                 (interp_mode == til_pkg::MODE_LIN_LOGY);

  always_comb begin
    pc32 = {23'd0, point_count};
    if (pc32 < 32'd2) begin
      last32 = 32'd1;
    end else if (pc32 > 32'(TABLE_DEPTH)) begin
      last32 = 32'(TABLE_DEPTH - 1);
    end else begin
      last32 = pc32 - 32'd1;
    end
    n_last  = last32[AW-1:0];
    mid_sum = {1'b0, lo} + {1'b0, hi};
    mid     = mid_sum[AW:1];
    idx32   = {24'd0, q_index};
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    case (cmd.op)
      til_pkg::DP_RD_FIRST: rd_addr = '0;
      til_pkg::DP_RD_LAST:  rd_addr = n_last;
      til_pkg::DP_RD_MID:   rd_addr = mid;
      til_pkg::DP_RD_LO:    rd_addr = hi - 1'b1;
      til_pkg::DP_TAKE_LO:  rd_addr = hi;
      default:              rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == til_pkg::DP_WRITE && idx32 < 32'(TABLE_DEPTH)) begin
      table_x[idx32[AW-1:0]] <= xq;
      table_y[idx32[AW-1:0]] <= q_y;
    end
    if (rd_en) begin
      rd_x <= table_x[rd_addr];
      rd_y <= table_y[rd_addr];
    end
  end

  always_comb begin
    case (cmd.src)
      til_pkg::SRC_XQ: lg_src = xq;
      til_pkg::SRC_X1: lg_src = x1;
      til_pkg::SRC_X2: lg_src = x2;
      til_pkg::SRC_Y1: lg_src = y1;
      default:         lg_src = y2;
    endcase
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (lg_src[i]) begin
        lead = 5'(i);
      end
    end
    lg_sq  = {32'd0, lg_m} * {32'd0, lg_m};
    lg_val = $signed({3'b000, lg_e, 24'd0}) - $signed(32'h1000_0000) +
             $signed({8'd0, lg_frac});
  end

  always_comb begin
    div_sh  = {rem[31:0], dvd[63]};
    quot    = dvd[32:0];
    ep_prod = {32'd0, ep} * {33'd0, til_pkg::EXP_ROOT[cmd.step]};
    ep_sum  = ep_prod + 65'h4000_0000;
    es      = 11'(eip) - 11'sd15;
    sh      = 11'(-es);
    rnd     = (sh == 11'd0) ? 34'd0 : (34'd1 << (sh[5:0] - 6'd1));
    rr      = ({1'b0, ep} + rnd) >> sh[5:0];
    exp_sat = 1'b0;
    exp_r   = '0;
    if (es > 11'sd0) begin
      exp_sat = 1'b1;
      exp_r   = 32'h7FFF_FFFF;
    end else if (sh >= 11'd33) begin
      exp_r = '0;
    end else if (rr > 34'h0_7FFF_FFFF) begin
      exp_sat = 1'b1;
      exp_r   = 32'h7FFF_FFFF;
    end else begin
      exp_r = rr[31:0];
    end
    if (log_y) begin
      dd = {ly2[31], ly2} - {ly1[31], ly1};
    end else begin
      dd = {y2[31], y2} - {y1[31], y1};
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      til_pkg::DP_CAPTURE: begin
        q_index <= in_data.entry_index;
        xq      <= in_data.point_x;
        q_y     <= in_data.point_y;
      end
      til_pkg::DP_SEARCH_INIT: begin
        lo <= '0;
        hi <= n_last;
      end
      til_pkg::DP_SEARCH_STEP: begin
        if (xq > rd_x) begin
          lo <= mid;
        end else begin
          hi <= mid;
        end
      end
      til_pkg::DP_TAKE_LO: begin
        x1 <= rd_x;
        y1 <= rd_y;
      end
      til_pkg::DP_TAKE_HI: begin
        x2 <= rd_x;
        y2 <= rd_y;
      end
      til_pkg::DP_RES_FIRST: begin
        res_y  <= rd_y;
        res_st <= til_pkg::ST_CLAMP_LOW;
      end
      til_pkg::DP_RES_LAST: begin
        res_y  <= rd_y;
        res_st <= til_pkg::ST_CLAMP_HIGH;
      end
      til_pkg::DP_RES_ZERO_Y: begin
        res_y  <= '0;
        res_st <= til_pkg::ST_NONPOS_Y;
      end
      til_pkg::DP_RES_ZERO_X: begin
        res_y  <= '0;
        res_st <= til_pkg::ST_ZERO_X;
      end
      til_pkg::DP_RES_FLAT: begin
        res_y  <= y1;
        res_st <= til_pkg::ST_FLAT_SAT;
      end
      til_pkg::DP_LOG_START: begin
        lg_e    <= lead;
        lg_m    <= lg_src << (5'd31 - lead);
        lg_frac <= '0;
      end
      til_pkg::DP_LOG_STEP: begin
        if (lg_sq[63]) begin
          lg_frac <= {lg_frac[LF-2:0], 1'b1};
          lg_m    <= lg_sq[63:32];
        end else begin
          lg_frac <= {lg_frac[LF-2:0], 1'b0};
          lg_m    <= lg_sq[62:31];
        end
      end
      til_pkg::DP_LOG_STORE: begin
        case (cmd.src)
          til_pkg::SRC_XQ: lq  <= lg_val;
          til_pkg::SRC_X1: l1  <= lg_val;
          til_pkg::SRC_X2: l2  <= lg_val;
          til_pkg::SRC_Y1: ly1 <= lg_val;
          default:         ly2 <= lg_val;
        endcase
      end
      til_pkg::DP_SPAN: begin
        if (log_x) begin
          num <= (lq > l1) ? 32'(lq - l1) : 32'd0;
          den <= (l2 > l1) ? 32'(l2 - l1) : 32'd0;
        end else begin
          num <= xq - x1;
          den <= x2 - x1;
        end
        base <= log_y ? ly1 : $signed(y1);
        neg  <= dd[32];
        mag  <= dd[32] ? 33'(-dd) : 33'(dd);
      end
      til_pkg::DP_MUL_INIT: begin
        acc    <= '0;
        mcand  <= {32'd0, (num > den) ? den : num};
        mplier <= mag;
      end
      til_pkg::DP_MUL_STEP: begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
      end
      til_pkg::DP_DIV_INIT: begin
        dvd <= acc + {33'd0, den[31:1]};
        rem <= '0;
      end
      til_pkg::DP_DIV_STEP: begin
        if (div_sh >= {1'b0, den}) begin
          rem <= div_sh - {1'b0, den};
          dvd <= {dvd[62:0], 1'b1};
        end else begin
          rem <= div_sh;
          dvd <= {dvd[62:0], 1'b0};
        end
      end
      til_pkg::DP_BLEND: begin
        if (neg) begin
          bl     <= 34'(base) - $signed({1'b0, quot});
          res_y  <= 32'(34'(base) - $signed({1'b0, quot}));
        end else begin
          bl     <= 34'(base) + $signed({1'b0, quot});
          res_y  <= 32'(34'(base) + $signed({1'b0, quot}));
        end
        res_st <= til_pkg::ST_OK;
      end
      til_pkg::DP_EXP_INIT: begin
        eip <= bl[33:24];
        ef  <= bl[LF-1:0];
        ep  <= 33'h0_8000_0000;
      end
      til_pkg::DP_EXP_STEP: begin
        if (ef[5'(LF - 1) - cmd.step]) begin
          ep <= ep_sum[63:31];
        end
      end
      til_pkg::DP_EXP_END: begin
        res_y  <= exp_r;
        res_st <= exp_sat ? til_pkg::ST_FLAT_SAT : til_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == til_pkg::DP_SEND) begin
      out_data.result_y <= res_y;
      out_data.status   <= res_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode <= til_pkg::MODE_LIN_LIN;
      point_count <= 9'd2;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          til_pkg::REG_INTERP_MODE: interp_mode <= cfg_data[1:0];
          til_pkg::REG_POINT_COUNT: point_count <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.op == til_pkg::DP_SEND) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_comb begin
    status.below    = xq < rd_x;
    status.above    = xq > rd_x;
    status.more     = {1'b0, hi} > ({1'b0, lo} + 1'b1);
    status.y_nonpos = log_y && ($signed(y1) <= 0 || $signed(y2) <= 0);
    status.x1_zero  = log_x && (x1 == 32'd0);
    status.log_x    = log_x;
    status.log_y    = log_y;
    status.den_zero = (den == 32'd0);
    status.out_full = out_valid;
  end

endmodule

[rtl/table_interpolator_lin_log.sv]
// ----------------------------------------------------------------------------
// Table interpolator, linear and logarithmic axes
// Piecewise table interpolation with saturation and status reporting.
// ----------------------------------------------------------------------------
// A load beat writes one table point. A query beat binary searches the
// table through one memory read port, then runs a serial log2 unit (three
// logarithms for a log x axis and two for a log y axis), a shift-add
// multiplier, a restoring divider and, for a log y axis, an exp2 unit. The
// next beat is taken while a finished result still waits in the output
// register.
module table_interpolator_lin_log #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  til_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output til_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_data
);

`include "table_interpolator_lin_log_assert.svh"

  til_pkg::dp_cmd_t    cmd;
  til_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  til_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  til_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `TIL_ASSERT_NEXT(a_query_busy, in_valid && in_ready && in_data.op == til_pkg::OP_QUERY, !in_ready, "query beat did not make the block busy")
  `TIL_ASSERT_LATER(a_load_done, in_valid && in_ready && in_data.op == til_pkg::OP_LOAD, in_ready, "load beat did not finish in two cycles")
  `TIL_ASSERT_SAME(a_status_code, out_valid, out_data.status <= til_pkg::ST_FLAT_SAT, "result beat carries an unknown status code")

endmodule
